@@ sv/sst_pkg.sv @@
// sst_pkg: shared constants, operation codes and cell command type
// for the sorted set table; no dependencies
package sst_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SIZE_W   = 7;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_MEMBER = 2'd2
    } t_op;

    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_cmd;

endpackage

@@ sv/sst_cell.sv @@
// sst_cell: one slot of the sorted chain, holds one element and
// shifts toward either neighbor on insert or remove; uses sst_pkg
module sst_cell (
    input  logic                             i_clk,
    input  sst_pkg::t_cell_cmd               i_cmd,
    input  logic                             i_active,
    input  logic signed [sst_pkg::DATA_W-1:0] i_elem,
    input  logic                             i_left_lt,
    input  logic signed [sst_pkg::DATA_W-1:0] i_left_val,
    input  logic signed [sst_pkg::DATA_W-1:0] i_right_val,
    output logic                             o_lt,
    output logic                             o_eq,
    output logic signed [sst_pkg::DATA_W-1:0] o_val
);

    logic signed [sst_pkg::DATA_W-1:0] r_val;
    logic signed [sst_pkg::DATA_W-1:0] n_val;

    assign o_lt  = i_active && (r_val < i_elem);
    assign o_eq  = i_active && (r_val == i_elem);
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        if (i_cmd.ins && !o_lt) begin
            n_val = i_left_lt ? i_elem : i_left_val;
        end else if (i_cmd.rem && !o_lt) begin
            n_val = i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

@@ sv/sorted_set_table_top.sv @@
// sorted_set_table_top: ascending set of distinct signed integers in a chain
// of sst_cell slots; uses sst_pkg and sst_cell
// result: strobe o_result_valid follows the start beat through r_busy and then r_valid, one cycle wide
// accept: no new start is taken while busy, during the compare-and-shift step
// across the whole chain; busy is high in the cycle after a start beat
// reset: synchronous active-low, empties the set; slot contents are not cleared
module sorted_set_table_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_operation,
    input  logic signed [sst_pkg::DATA_W-1:0] i_element,
    output logic                              o_result_valid,
    output logic                              o_was_present,
    output logic                              o_status,
    output logic [sst_pkg::SIZE_W-1:0]        o_set_size
);

    logic                              r_busy;
    logic [1:0]                        r_op;
    logic signed [sst_pkg::DATA_W-1:0] r_elem;
    logic [sst_pkg::CNT_W-1:0]         r_count;
    logic [sst_pkg::CNT_W-1:0]         n_count;
    logic                              r_valid;
    logic                              r_present;
    logic                              r_status;
    logic [sst_pkg::SIZE_W-1:0]        r_size;

    logic [sst_pkg::CAPACITY-1:0]      w_lt;
    logic [sst_pkg::CAPACITY-1:0]      w_eq;
    logic [sst_pkg::CAPACITY-1:0]      w_active;
    logic signed [sst_pkg::DATA_W-1:0] w_val [sst_pkg::CAPACITY];

    logic                              present;
    logic                              full;
    logic                              reject;
    sst_pkg::t_cell_cmd                cmd;

    assign busy = r_busy;

    assign present = |w_eq;
    assign full    = (r_count >= sst_pkg::CNT_W'(sst_pkg::CAPACITY));

    always_comb begin
        cmd.ins = 1'b0;
        cmd.rem = 1'b0;
        reject  = 1'b0;
        n_count = r_count;
        if (r_busy) begin
            if (r_op == sst_pkg::OP_INSERT && !present) begin
                if (full) begin
                    reject = 1'b1;
                end else begin
                    cmd.ins = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end else if (r_op == sst_pkg::OP_REMOVE && present) begin
                cmd.rem = 1'b1;
                n_count = r_count - 1'b1;
            end
        end
    end

    for (genvar i = 0; i < sst_pkg::CAPACITY; i++) begin : g_cell
        logic                              left_lt;
        logic signed [sst_pkg::DATA_W-1:0] left_val;
        logic signed [sst_pkg::DATA_W-1:0] right_val;

        assign w_active[i] = (sst_pkg::CNT_W'(i) < r_count);

        if (i == 0) begin : g_first
            assign left_lt  = 1'b1;
            assign left_val = r_elem;
        end else begin : g_mid
            assign left_lt  = w_lt[i-1];
            assign left_val = w_val[i-1];
        end

        if (i == sst_pkg::CAPACITY - 1) begin : g_last
            assign right_val = w_val[i];
        end else begin : g_inner
            assign right_val = w_val[i+1];
        end

        sst_cell u_cell (
            .i_clk       (i_clk),
            .i_cmd       (cmd),
            .i_active    (w_active[i]),
            .i_elem      (r_elem),
            .i_left_lt   (left_lt),
            .i_left_val  (left_val),
            .i_right_val (right_val),
            .o_lt        (w_lt[i]),
            .o_eq        (w_eq[i]),
            .o_val       (w_val[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_busy  <= start && !r_busy;
            r_count <= n_count;
            r_valid <= r_busy;
        end
    end

    // input beat capture and result registers
    always_ff @(posedge i_clk) begin
        if (start && !r_busy) begin
            r_op   <= i_operation;
            r_elem <= i_element;
        end
        if (r_busy) begin
            r_present <= present;
            r_status  <= reject;
            r_size    <= sst_pkg::SIZE_W'(n_count);
        end
    end

    assign o_result_valid = r_valid;
    assign o_was_present  = r_present;
    assign o_status       = r_status;
    assign o_set_size     = r_size;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= sst_pkg::CNT_W'(sst_pkg::CAPACITY))
        else $error("element count beyond capacity");

    a_busy_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> r_valid && !r_busy)
        else $error("operation did not produce one result");

    a_reject_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        reject |-> full && !present && !cmd.ins && !cmd.rem)
        else $error("reject without full set");

    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> $onehot0(w_eq))
        else $error("duplicate element in chain");
`endif

endmodule

@@ test/sorted_set_table_top_test.sv @@
// sorted_set_table_top_test: self-checking bench for the sorted set table; keeps its own
// ordered copy of the set, predicts every reply and checks each strobed result against it
// depends on sst_pkg and sorted_set_table_top
module sorted_set_table_top_test;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam int         IDLE_LIMIT = 500;
    localparam int         POOL_SIZE  = 96;

    typedef struct packed {
        logic                       was_present;
        logic                       status;
        logic [sst_pkg::SIZE_W-1:0] set_size;
    } t_set_reply;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              start = 1'b0;
    logic                              busy;
    logic [1:0]                        i_operation = '0;
    logic signed [sst_pkg::DATA_W-1:0] i_element = '0;
    logic                              o_result_valid;
    logic                              o_was_present;
    logic                              o_status;
    logic [sst_pkg::SIZE_W-1:0]        o_set_size;

    logic signed [sst_pkg::DATA_W-1:0] held_elems [sst_pkg::CAPACITY];
    int                                held_count = 0;
    logic signed [sst_pkg::DATA_W-1:0] value_pool [POOL_SIZE];
    t_set_reply                        pending_replies [$];
    int                                mismatches = 0;
    int                                gap_pct = 0;
    int                                idle_cycles = 0;

    sorted_set_table_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_element      (i_element),
        .o_result_valid (o_result_valid),
        .o_was_present  (o_was_present),
        .o_status       (o_status),
        .o_set_size     (o_set_size)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_set_reply apply_set_op(logic [1:0] op,
                                                logic signed [sst_pkg::DATA_W-1:0] x);
        int         pos;
        bit         found;
        t_set_reply reply;
        pos = 0;
        while (pos < held_count && held_elems[pos] < x)
            pos++;
        found = (pos < held_count) && (held_elems[pos] == x);
        reply.status = 1'b0;
        if (op == sst_pkg::OP_INSERT && !found) begin
            if (held_count >= sst_pkg::CAPACITY) begin
                reply.status = 1'b1;
            end else begin
                for (int i = held_count; i > pos; i--)
                    held_elems[i] = held_elems[i - 1];
                held_elems[pos] = x;
                held_count++;
            end
        end else if (op == sst_pkg::OP_REMOVE && found) begin
            for (int i = pos; i + 1 < held_count; i++)
                held_elems[i] = held_elems[i + 1];
            held_count--;
        end
        reply.was_present = found;
        reply.set_size = held_count[sst_pkg::SIZE_W-1:0];
        return reply;
    endfunction

    function automatic logic [1:0] pick_op(int ins_pct, int rem_pct, int mem_pct);
        int r;
        r = $urandom_range(99);
        if (r < ins_pct)
            return sst_pkg::OP_INSERT;
        if (r < ins_pct + rem_pct)
            return sst_pkg::OP_REMOVE;
        if (r < ins_pct + rem_pct + mem_pct)
            return sst_pkg::OP_MEMBER;
        return OP_UNUSED;
    endfunction

    function automatic logic signed [sst_pkg::DATA_W-1:0] pick_element(int wild_pct);
        if ($urandom_range(99) < wild_pct)
            return $urandom;
        return value_pool[$urandom_range(POOL_SIZE - 1)];
    endfunction

    task automatic refill_pool();
        int base;
        base = $urandom;
        for (int i = 0; i < POOL_SIZE; i++) begin
            case ($urandom_range(3))
                0: value_pool[i] = $urandom;
                1: value_pool[i] = $signed(32'($urandom_range(40))) - 20;
                2: value_pool[i] = base + i;
                default: value_pool[i] = $urandom_range(1) ? 32'h7fff_ffff - i : 32'h8000_0000 + i;
            endcase
        end
    endtask

    task automatic idle_burst();
        int n;
        n = $urandom_range(19, 1);
        start <= 1'b0;
        for (int k = 0; k < n; k++) begin
            i_operation <= $urandom;
            i_element <= $urandom;
            @(posedge i_clk);
        end
    endtask

    // drive one beat and wait for the handshake; returns at the accepting edge
    task automatic send_item(logic [1:0] op, logic signed [sst_pkg::DATA_W-1:0] x);
        if (gap_pct > 0 && $urandom_range(99) < gap_pct)
            idle_burst();
        start <= 1'b1;
        i_operation <= op;
        i_element <= x;
        do
            @(posedge i_clk);
        while (busy);
        pending_replies.push_back(apply_set_op(op, x));
    endtask

    task automatic pick_gap_pct();
        case ($urandom_range(3))
            0: gap_pct = 0;
            1: gap_pct = 10;
            2: gap_pct = 30;
            default: gap_pct = 60;
        endcase
    endtask

    task automatic test_empty_set();
        send_item(sst_pkg::OP_MEMBER, 32'sd0);
        send_item(sst_pkg::OP_REMOVE, 32'sd0);
    endtask

    task automatic test_extremes();
        send_item(sst_pkg::OP_INSERT, 32'h8000_0000);
        send_item(sst_pkg::OP_INSERT, 32'h7fff_ffff);
        send_item(sst_pkg::OP_INSERT, 32'sd0);
        send_item(sst_pkg::OP_INSERT, -32'sd1);
        send_item(sst_pkg::OP_INSERT, 32'sd1);
        send_item(sst_pkg::OP_MEMBER, 32'h8000_0000);
        send_item(sst_pkg::OP_MEMBER, 32'h7fff_ffff);
        send_item(sst_pkg::OP_INSERT, 32'h7fff_ffff);
        send_item(sst_pkg::OP_REMOVE, 32'sd0);
        send_item(sst_pkg::OP_REMOVE, 32'sd0);
        send_item(sst_pkg::OP_MEMBER, 32'sd0);
    endtask

    task automatic test_unused_opcode();
        send_item(OP_UNUSED, 32'h7fff_ffff);
        send_item(OP_UNUSED, 32'sd0);
        send_item(OP_UNUSED, 32'haaaa_5555);
    endtask

    task automatic test_remove_extremes();
        send_item(sst_pkg::OP_REMOVE, 32'h8000_0000);
        send_item(sst_pkg::OP_REMOVE, 32'h7fff_ffff);
        send_item(sst_pkg::OP_MEMBER, 32'h8000_0000);
    endtask

    // insert-heavy runs push the set to capacity and into rejected inserts; remove-heavy runs drain it
    task automatic test_fill_and_drain();
        for (int round = 0; round < 3; round++) begin
            refill_pool();
            pick_gap_pct();
            for (int n = 0; n < 150; n++)
                send_item(pick_op(80, 5, 10), pick_element(5));
            pick_gap_pct();
            for (int n = 0; n < 150; n++)
                send_item(pick_op(5, 80, 10), pick_element(5));
        end
    endtask

    task automatic test_random_mix();
        for (int chunk = 0; chunk < 8; chunk++) begin
            if (chunk % 3 == 0)
                refill_pool();
            pick_gap_pct();
            for (int n = 0; n < 100; n++)
                send_item(pick_op(40, 30, 25), pick_element(20));
        end
    endtask

    task automatic test_back_to_back();
        gap_pct = 0;
        refill_pool();
        for (int n = 0; n < 150; n++)
            send_item(pick_op(45, 30, 20), pick_element(10));
    endtask

    always @(posedge i_clk) begin
        t_set_reply want;
        if (i_rst_n && o_result_valid) begin
            if (pending_replies.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result: was_present=%0b status=%0b set_size=%0d",
                             o_was_present, o_status, o_set_size);
                mismatches++;
            end else begin
                want = pending_replies.pop_front();
                if (o_was_present !== want.was_present || o_status !== want.status ||
                    o_set_size !== want.set_size) begin
                    if (mismatches < 10)
                        $display({"mismatch: expected was_present=%0b status=%0b set_size=%0d,",
                                  " got was_present=%0b status=%0b set_size=%0d"},
                                 want.was_present, want.status, want.set_size,
                                 o_was_present, o_status, o_set_size);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_set();
        test_extremes();
        test_unused_opcode();
        test_remove_extremes();
        test_fill_and_drain();
        test_random_mix();
        test_back_to_back();
        start <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        if (pending_replies.size() != 0) begin
            $display("results missing: %0d", pending_replies.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ sim.f @@
sv/sst_pkg.sv
sv/sst_cell.sv
sv/sorted_set_table_top.sv
test/sorted_set_table_top_test.sv
